// ===== rtl/pol_pkg.sv =====
package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [OP_W-1:0] OP_READ_ALL  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd6;
  localparam logic [OP_W-1:0] OP_NONE      = 3'd7;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_INS  = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;

  localparam logic [1:0] SEL_FRONT = 2'd0;
  localparam logic [1:0] SEL_BACK  = 2'd1;
  localparam logic [1:0] SEL_AT    = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [1:0]              sel;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } back_stat_t;

endpackage

// ===== rtl/pol_front.sv =====
module pol_front
  import pol_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [VAL_W-1:0] in_value_in,
  input  logic [POS_W-1:0]        in_position,
  output logic                    q_valid,
  output cmd_t                    q_cmd,
  input  logic                    q_pop
);

  localparam int QD = 2;

  cmd_t       q_r [QD];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd;
  logic       keep;
  logic       push;

  always_comb begin
    cmd.value    = in_value_in;
    cmd.position = in_position;
    cmd.kind     = KIND_READ;
    cmd.sel      = SEL_FRONT;
    keep         = 1'b1;
    unique case (in_op)
      OP_READ_ALL: begin
        cmd.kind = KIND_READ;
      end
      OP_INS_FRONT: begin
        cmd.kind = KIND_INS;
        cmd.sel  = SEL_FRONT;
      end
      OP_INS_BACK: begin
        cmd.kind = KIND_INS;
        cmd.sel  = SEL_BACK;
      end
      OP_INS_AT: begin
        cmd.kind = KIND_INS;
        cmd.sel  = SEL_AT;
      end
      OP_DEL_FRONT: begin
        cmd.kind = KIND_DEL;
        cmd.sel  = SEL_FRONT;
      end
      OP_DEL_BACK: begin
        cmd.kind = KIND_DEL;
        cmd.sel  = SEL_BACK;
      end
      OP_DEL_AT: begin
        cmd.kind = KIND_DEL;
        cmd.sel  = SEL_AT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (cnt_r == 2'(QD));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== rtl/pol_back.sv =====
module pol_back
  import pol_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  cmd_t                     q_cmd,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_value_out,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_last,
  output back_stat_t               stat
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                    state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic signed [VAL_W-1:0] slots_r [CAPACITY];
  logic signed [VAL_W-1:0] slots_nxt [CAPACITY];
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    ofree;
  logic [POS_W-1:0]        cnt_ext;
  logic [POS_W-1:0]        ins_idx;
  logic [POS_W-1:0]        del_idx;
  logic                    del_bad;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [VAL_W-1:0] rd_data;
  logic                    rd_last;

  assign ofree   = !out_valid_r || !out_stall;
  assign cnt_ext = POS_W'(count_r);

  always_comb begin
    case (q_cmd.sel)
      SEL_FRONT: ins_idx = '0;
      SEL_BACK:  ins_idx = cnt_ext;
      default:   ins_idx = q_cmd.position;
    endcase
    case (q_cmd.sel)
      SEL_FRONT: del_idx = '0;
      SEL_BACK:  del_idx = cnt_ext - POS_W'(1);
      default:   del_idx = q_cmd.position - POS_W'(1);
    endcase
    del_bad = ((q_cmd.sel == SEL_AT) && (q_cmd.position == '0)) || (del_idx >= cnt_ext);
  end

  assign rd_addr = (state_r == ST_READ) ? rd_idx_r : del_idx[IDX_W-1:0];
  assign rd_data = slots_r[rd_addr];
  assign rd_last = (CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_stall ? out_valid_r : 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      slots_nxt[i] = slots_r[i];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && ofree) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            KIND_READ: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = STAT_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt  = ST_READ;
                rd_idx_nxt = '0;
              end
            end
            KIND_INS: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              out_value_nxt = '0;
              if (count_r == CNT_W'(CAPACITY)) begin
                out_status_nxt = STAT_FULL;
              end else if (ins_idx > cnt_ext) begin
                out_status_nxt = STAT_BADPOS;
              end else begin
                out_status_nxt = STAT_OK;
                out_value_nxt  = q_cmd.value;
                count_nxt      = count_r + CNT_W'(1);
                for (int i = 0; i < CAPACITY; i++) begin
                  if (POS_W'(i) == ins_idx) begin
                    slots_nxt[i] = q_cmd.value;
                  end else if ((i > 0) && (POS_W'(i) > ins_idx)) begin
                    slots_nxt[i] = slots_r[(i > 0) ? i - 1 : 0];
                  end
                end
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              out_value_nxt = '0;
              if (count_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else if (del_bad) begin
                out_status_nxt = STAT_BADPOS;
              end else begin
                out_status_nxt = STAT_OK;
                out_value_nxt  = rd_data;
                count_nxt      = count_r - CNT_W'(1);
                for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (POS_W'(i) >= del_idx) begin
                    slots_nxt[i] = slots_r[i + 1];
                  end
                end
              end
            end
          endcase
        end
      end
      ST_READ: begin
        if (ofree) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data;
          out_status_nxt = STAT_OK;
          out_last_nxt   = rd_last;
          rd_idx_nxt     = rd_idx_r + IDX_W'(1);
          if (rd_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    for (int i = 0; i < CAPACITY; i++) begin
      slots_r[i] <= slots_nxt[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;
  assign stat.busy     = (state_r == ST_READ);
  assign stat.count    = count_r;

endmodule

// ===== rtl/positional_ordered_list_core.sv =====
// positional ordered list: up to CAPACITY signed 32-bit values kept in order
// input channel in_valid/in_stall carries op, value_in and position
// op 7 is taken and dropped without any result
// a two-entry command queue sits behind the input; in_stall rises only when it is full
// result channel out_valid/out_stall carries value_out, status and last
// each command is registered in the queue, then its result in the result register
// insert and delete ops: one result each, one op per cycle while out_stall is low
// read all: count results after a setup step, one per cycle while out_stall is low;
// the element shift line and its single read select set these rates
// an empty read all gives one result with status empty
// while a result waits under out_stall, it is held and the back end waits;
// the front keeps taking items until the queue fills
// reset (rst_n low, synchronous) empties the list and the queue and drops any
// pending result; element contents are not cleared
module positional_ordered_list_core
  import pol_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [VAL_W-1:0] in_value_in,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_value_out,
  output logic [STAT_W-1:0]       out_status,
  output logic                    out_last
);

  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_pop;
  back_stat_t stat;

  pol_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_value_in(in_value_in),
    .in_position(in_position),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  pol_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value_out(out_value_out),
    .out_status   (out_status),
    .out_last     (out_last),
    .stat         (stat)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (stat.count == $past(stat.count) ||
                      stat.count == $past(stat.count) + CNT_W'(1) ||
                      stat.count + CNT_W'(1) == $past(stat.count)))
    else $error("element count moved by more than one");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_last && (out_value_out == '0))
    else $error("error result not a single zero-valued transfer");

  a_read_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !q_pop)
    else $error("command popped during read out");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pol_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 80;
  localparam int ITEMS_PER_PHASE = 140;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
    logic                    is_last;
  } list_result_t;

  class list_scoreboard;
    logic signed [VAL_W-1:0] contents[$];
    list_result_t            awaited[$];
    int errors;
    int ops_noted;
    int results_checked;
    int deepest;
    int full_reports;
    int empty_reports;
    int badpos_reports;

    function void expect_result(logic signed [VAL_W-1:0] value, logic [STAT_W-1:0] status,
                                logic is_last);
      list_result_t r;
      r.value   = value;
      r.status  = status;
      r.is_last = is_last;
      awaited.push_back(r);
      if (status == STAT_FULL) full_reports++;
      if (status == STAT_EMPTY) empty_reports++;
      if (status == STAT_BADPOS) badpos_reports++;
    endfunction

    function void insert_entry(int idx, logic signed [VAL_W-1:0] value);
      if (contents.size() >= CAPACITY) begin
        expect_result('0, STAT_FULL, 1'b1);
      end else if (idx > contents.size()) begin
        expect_result('0, STAT_BADPOS, 1'b1);
      end else begin
        contents.insert(idx, value);
        expect_result(value, STAT_OK, 1'b1);
      end
    endfunction

    function void remove_entry(int idx);
      logic signed [VAL_W-1:0] value;
      if (contents.size() == 0) begin
        expect_result('0, STAT_EMPTY, 1'b1);
      end else if (idx >= contents.size()) begin
        expect_result('0, STAT_BADPOS, 1'b1);
      end else begin
        value = contents[idx];
        contents.delete(idx);
        expect_result(value, STAT_OK, 1'b1);
      end
    endfunction

    function void note_op(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value,
                          logic [POS_W-1:0] position);
      int n;
      n = contents.size();
      ops_noted++;
      case (op)
        OP_READ_ALL: begin
          if (n == 0) begin
            expect_result('0, STAT_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) expect_result(contents[i], STAT_OK, i == n - 1);
          end
        end
        OP_INS_FRONT: insert_entry(0, value);
        OP_INS_BACK:  insert_entry(n, value);
        OP_DEL_FRONT: remove_entry(0);
        OP_DEL_BACK:  remove_entry(n == 0 ? 0 : n - 1);
        OP_INS_AT:    insert_entry(int'(position), value);
        OP_DEL_AT: begin
          if (n == 0) begin
            expect_result('0, STAT_EMPTY, 1'b1);
          end else if (position == 0) begin
            expect_result('0, STAT_BADPOS, 1'b1);
          end else begin
            remove_entry(int'(position) - 1);
          end
        end
        default: ;
      endcase
      if (contents.size() > deepest) deepest = contents.size();
    endfunction

    function void check_result(logic signed [VAL_W-1:0] value, logic [STAT_W-1:0] status,
                               logic is_last);
      list_result_t want;
      results_checked++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result value_out %0d status %0d last %0b",
                 $time, value, status, is_last);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        $display("%0t: value_out expected %0d actual %0d", $time, want.value, value);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.is_last, is_last);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function int depth();
      return contents.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op = OP_NONE;
  logic signed [VAL_W-1:0] in_value_in = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_value_out;
  logic [STAT_W-1:0]       out_status;
  logic                    out_last;

  list_scoreboard sb;
  int  sender_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  growing = 1'b1;

  positional_ordered_list_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_value_in   (in_value_in),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_out (out_value_out),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall plus one long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_value_out, out_status, out_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_list_op(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value,
                              logic [POS_W-1:0] position);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_value_in <= value;
    in_position <= position;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_op(op, value, position);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(9) != 0) return $urandom();
    case ($urandom_range(3))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return -32'sd1;
    endcase
  endfunction

  // mostly legal positions, drifting between empty and full
  function automatic void next_list_op(output logic [OP_W-1:0] op,
                                       output logic signed [VAL_W-1:0] value,
                                       output logic [POS_W-1:0] position);
    int n;
    int r;
    bit bad;
    n = sb.depth();
    if (n >= CAPACITY) growing = 1'b0;
    if (n == 0) growing = 1'b1;
    r        = $urandom_range(99);
    bad      = ($urandom_range(9) == 0);
    value    = pick_value();
    position = POS_W'($urandom_range(64));
    if (r < 8) begin
      op = OP_READ_ALL;
    end else if (r < 10) begin
      op = OP_NONE;
    end else if ($urandom_range(99) < (growing ? 70 : 30)) begin
      case ($urandom_range(2))
        0:       op = OP_INS_FRONT;
        1:       op = OP_INS_BACK;
        default: op = OP_INS_AT;
      endcase
      if (op == OP_INS_AT) begin
        position = bad ? POS_W'($urandom_range(64, n + 1)) : POS_W'($urandom_range(n, 0));
      end
    end else begin
      case ($urandom_range(2))
        0:       op = OP_DEL_FRONT;
        1:       op = OP_DEL_BACK;
        default: op = OP_DEL_AT;
      endcase
      if (op == OP_DEL_AT && n != 0) begin
        if (!bad) position = POS_W'($urandom_range(n, 1));
        else if ($urandom_range(1) == 0) position = '0;
        else position = POS_W'($urandom_range(64, n + 1));
      end
    end
  endfunction

  initial begin
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    int done;

    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 19;
    recv_idle_pct   = 52;

    // empty list: read and every delete, then inserts, bad positions and a full list
    send_list_op(OP_READ_ALL, '0, '0);
    send_list_op(OP_DEL_FRONT, '0, '0);
    send_list_op(OP_DEL_BACK, '0, '0);
    send_list_op(OP_DEL_AT, '0, '0);
    send_list_op(OP_DEL_AT, '0, 7'd64);
    send_list_op(OP_INS_AT, 32'sd5, 7'd1);
    send_list_op(OP_INS_AT, 32'sh7fff_ffff, 7'd0);
    send_list_op(OP_INS_FRONT, 32'sh8000_0000, '0);
    send_list_op(OP_INS_BACK, '0, '0);
    send_list_op(OP_INS_BACK, -32'sd1, '0);
    send_list_op(OP_READ_ALL, '0, '0);
    send_list_op(OP_DEL_AT, '0, 7'd0);
    send_list_op(OP_DEL_AT, '0, 7'd5);
    send_list_op(OP_DEL_AT, '0, 7'd1);
    send_list_op(OP_INS_AT, 32'sh1234_5678, 7'd3);
    send_list_op(OP_INS_AT, 32'sd9, 7'd64);
    send_list_op(OP_NONE, 32'sd77, 7'd127);
    send_list_op(OP_DEL_BACK, '0, '0);
    send_list_op(OP_DEL_FRONT, '0, '0);
    while (sb.depth() < CAPACITY) send_list_op(OP_INS_BACK, $urandom(), '0);
    send_list_op(OP_INS_FRONT, 32'sd1, '0);
    send_list_op(OP_INS_AT, 32'sd2, 7'd64);
    send_list_op(OP_INS_BACK, 32'sd3, '0);
    send_list_op(OP_READ_ALL, '0, '0);
    send_list_op(OP_DEL_AT, '0, 7'(CAPACITY));
    wait_for_drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 19;
          recv_idle_pct   = 52;
        end
        1: begin
          sender_idle_pct = 52;
          recv_idle_pct   = 19;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct   = 0;
        end
      endcase
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        next_list_op(op, value, position);
        send_list_op(op, value, position);
        if (op != OP_NONE) begin
          done++;
          if (phase == 0 && done == 60) hold_req = 1'b1;
          if (done == 100) wait_for_drain();
        end
      end
      wait_for_drain();
    end

    repeat (24) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.outstanding());
      sb.errors += sb.outstanding();
    end
    $display("run covered %0d list ops and %0d results, list depth up to %0d",
             sb.ops_noted, sb.results_checked, sb.deepest);
    $display("full reported %0d times, empty %0d times, bad position %0d times",
             sb.full_reports, sb.empty_reports, sb.badpos_reports);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
